// ===== hw/rtl/pttd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pttd_pkg
// Types and constants shared by the periodic task tick dispatcher.
// ----------------------------------------------------------------------------
package pttd_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int TIME_W         = 32;
    localparam int OVR_SLOT_W     = 4;
    localparam int SLOT_OUT_W     = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [OVR_SLOT_W-1:0] OVR_SLOT_RESET = OVR_SLOT_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_SLOT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_PERIOD = CFG_IDX_W'(1);

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_CREATE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] task_period;
        logic [TIME_W-1:0] start_delay;
    } cmd_beat_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] task_slot;
        logic                  last_due;
    } run_beat_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              tick_start;
        logic              create;
        logic              advance;
        logic              use_override;
        logic [TIME_W-1:0] override_period;
        logic [TIME_W-1:0] task_period;
        logic [TIME_W-1:0] start_delay;
    } cell_ctrl_t;

    // status of one cell, also handed to its right-hand neighbour
    typedef struct packed {
        logic filled;
        logic ahead;
        logic visit;
        logic due;
        logic pend_due;
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pttd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pttd_cell
// One task slot: filled flag, countdown, reload period and scan flag.
// ----------------------------------------------------------------------------
module pttd_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pttd_pkg::cell_ctrl_t ctrl,
    input  wire logic                prev_filled,
    input  wire logic                prev_ahead,
    output pttd_pkg::cell_stat_t     stat
);

    logic                        filled_reg, filled_next;
    logic                        ahead_reg, ahead_next;
    logic [pttd_pkg::TIME_W-1:0] count_reg, count_next;
    logic [pttd_pkg::TIME_W-1:0] period_reg, period_next;
    logic [pttd_pkg::TIME_W-1:0] dec;
    logic                        visit;
    logic                        at_one;

    assign visit  = ahead_reg & ~prev_ahead;
    assign dec    = count_reg - pttd_pkg::TIME_W'(1);
    assign at_one = (count_reg == pttd_pkg::TIME_W'(1));

    always_comb
    begin
        filled_next = filled_reg;
        ahead_next  = ahead_reg;
        count_next  = count_reg;
        period_next = period_reg;
        if (ctrl.tick_start)
        begin
            ahead_next = 1'b1;
        end
        if (ctrl.create && prev_filled && !filled_reg)
        begin
            filled_next = 1'b1;
            period_next = ctrl.task_period;
            count_next  = ctrl.start_delay + pttd_pkg::TIME_W'(1);
        end
        if (ctrl.advance && visit)
        begin
            ahead_next = 1'b0;
            if (filled_reg)
            begin
                if (at_one)
                begin
                    count_next = ctrl.use_override ? ctrl.override_period : period_reg;
                end
                else
                begin
                    count_next = dec;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            ahead_reg  <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            ahead_reg  <= ahead_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        period_reg <= period_next;
    end

    always_comb
    begin
        stat.filled   = filled_reg;
        stat.ahead    = ahead_reg;
        stat.visit    = visit;
        stat.due      = visit & filled_reg & at_one;
        stat.pend_due = ahead_reg & ~visit & filled_reg & at_one;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_task_tick_dispatcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_tick_dispatcher
// Time-triggered cooperative scheduler built as a row of task slot cells.
// ----------------------------------------------------------------------------
// A create beat fills the next free slot; once all SLOT_COUNT slots hold
// tasks, further creates are dropped. An accepted tick beat starts a scan:
// a visit mark moves from cell to cell, one slot per cycle, decrementing
// and reloading as it goes, and every slot that falls due sends one result
// beat (low three bits of the slot number, last_due on the final one).
// While a result is stalled the scan waits. cmd_stall is high for the whole
// scan. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module periodic_task_tick_dispatcher #(
    parameter int SLOT_COUNT = pttd_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire pttd_pkg::cmd_beat_t            cmd_data,
    output logic                                run_valid,
    input  wire logic                           run_stall,
    output pttd_pkg::run_beat_t                 run_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pttd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pttd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W = (IDX_W > pttd_pkg::OVR_SLOT_W) ? IDX_W : pttd_pkg::OVR_SLOT_W;

    logic [pttd_pkg::OVR_SLOT_W-1:0] ovr_slot_reg;
    logic [pttd_pkg::TIME_W-1:0]     ovr_period_reg;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            out_valid_reg, out_valid_next;
    pttd_pkg::run_beat_t             out_data_reg, out_data_next;

    pttd_pkg::cell_ctrl_t            ctrl;
    pttd_pkg::cell_stat_t            stat [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]           ahead_vec;
    logic [SLOT_COUNT-1:0]           visit_vec;
    logic [SLOT_COUNT-1:0]           due_vec;
    logic [SLOT_COUNT-1:0]           pend_vec;
    logic                            busy;
    logic                            cmd_take;
    logic                            advance;
    logic                            due_any;

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                pttd_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .prev_filled (1'b1),
                    .prev_ahead  (1'b0),
                    .stat        (stat[g])
                );
            end
            else
            begin : g_body
                pttd_cell u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .prev_filled (stat[g-1].filled),
                    .prev_ahead  (stat[g-1].ahead),
                    .stat        (stat[g])
                );
            end
            assign ahead_vec[g] = stat[g].ahead;
            assign visit_vec[g] = stat[g].visit;
            assign due_vec[g]   = stat[g].due;
            assign pend_vec[g]  = stat[g].pend_due;
        end
    endgenerate

    assign busy      = |ahead_vec;
    assign due_any   = |due_vec;
    assign cmd_stall = busy;
    assign cmd_take  = cmd_valid & ~busy;
    assign advance   = busy & (~out_valid_reg | ~run_stall);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        ctrl.tick_start      = cmd_take & (cmd_data.command == pttd_pkg::CMD_TICK);
        ctrl.create          = cmd_take & (cmd_data.command == pttd_pkg::CMD_CREATE);
        ctrl.advance         = advance;
        ctrl.use_override    = (CMP_W'(idx_reg) == CMP_W'(ovr_slot_reg));
        ctrl.override_period = ovr_period_reg;
        ctrl.task_period     = cmd_data.task_period;
        ctrl.start_delay     = cmd_data.start_delay;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.tick_start)
        begin
            idx_next = '0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !run_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && due_any)
        begin
            out_valid_next         = 1'b1;
            out_data_next.task_slot = pttd_pkg::SLOT_OUT_W'(idx_reg);
            out_data_next.last_due  = ~(|pend_vec);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovr_slot_reg   <= pttd_pkg::OVR_SLOT_RESET;
            ovr_period_reg <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pttd_pkg::REG_OVERRIDE_SLOT:
                        ovr_slot_reg <= cfg_data[pttd_pkg::OVR_SLOT_W-1:0];
                    pttd_pkg::REG_OVERRIDE_PERIOD:
                        ovr_period_reg <= cfg_data[pttd_pkg::TIME_W-1:0];
                    default:
                        ;
                endcase
            end
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign run_valid = out_valid_reg;
    assign run_data  = out_data_reg;

    // the visit mark sits on exactly one cell during a scan, the one the counter names
    a_visit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> $onehot(visit_vec))
        else $error("scan visit mark not one-hot");

    a_visit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (visit_vec == '0))
        else $error("visit mark outside a scan");

    a_idx_track: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> visit_vec[idx_reg])
        else $error("slot counter out of step with visit mark");

    a_no_late_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !out_valid_reg) |=> !out_valid_reg)
        else $error("result beat without a scan");

endmodule

`default_nettype wire

// ===== dv/periodic_task_tick_dispatcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_dispatcher_tb
// Self-checking bench for the task slot table and its tick scan.
// ----------------------------------------------------------------------------
// The bench fills the slot table with a directed mix of dead, always-due and
// far-off tasks, then overflows it. It then runs phases of random ticks, with
// stray creates mixed in, under several override settings. Each accepted
// command beat updates a local copy of the table, which yields the due slots
// of every tick. Every run beat is checked in order against them. Both sides
// idle at random, apart from one calm phase.
// ----------------------------------------------------------------------------
module periodic_task_tick_dispatcher_tb;
    import pttd_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int PHASES = 5;
    localparam int TICKS_PER_PHASE = 50;
    localparam int SETTLE = SLOTS + 8;
    localparam int LIMIT = 400000;
    localparam logic [0:PHASES-1][OVR_SLOT_W-1:0] PHASE_SLOT =
        {4'd1, 4'd6, 4'd8, 4'd7, 4'd0};
    localparam logic [0:PHASES-1][CFG_DATA_W-1:0] PHASE_PERIOD =
        {32'd3, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_beat_t             cmd_data = '0;
    logic                  run_valid;
    logic                  run_stall = 1'b0;
    run_beat_t             run_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cmd_beat_t cmd_pending[$];
    run_beat_t due_runs[$];
    int        cmd_gap = 0;
    int        stall_cnt = 0;
    int        errors = 0;
    int        cycles = 0;
    bit        calm = 1'b0;

    // local copy of the slot table
    bit                    slot_used [SLOTS];
    bit [TIME_W-1:0]       slot_count [SLOTS];
    bit [TIME_W-1:0]       slot_reload [SLOTS];
    int                    next_slot = 0;
    logic [OVR_SLOT_W-1:0] ovr_slot = OVR_SLOT_RESET;
    bit [TIME_W-1:0]       ovr_period = '0;

    periodic_task_tick_dispatcher #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_data(cmd_data),
        .run_valid(run_valid),
        .run_stall(run_stall),
        .run_data(run_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic schedule_step(input cmd_beat_t b);
        int        hits[$];
        run_beat_t r;
        if (b.command == CMD_CREATE) begin
            if (next_slot < SLOTS) begin
                slot_used[next_slot] = 1'b1;
                slot_reload[next_slot] = b.task_period;
                slot_count[next_slot] = b.start_delay + 1;
                next_slot++;
            end
        end
        else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i]) begin
                    slot_count[i] = slot_count[i] - 1;
                    if (slot_count[i] == 0) begin
                        slot_count[i] = (i == ovr_slot) ? ovr_period : slot_reload[i];
                        hits.push_back(i);
                    end
                end
            end
            foreach (hits[k]) begin
                r.task_slot = SLOT_OUT_W'(hits[k]);
                r.last_due = (k == hits.size() - 1);
                due_runs.push_back(r);
            end
        end
    endtask

    function automatic logic [TIME_W-1:0] rand_delay();
        logic [TIME_W-1:0] d;
        d = $urandom;
        return (d == '1) ? d - 1 : d;
    endfunction

    function automatic cmd_beat_t create_beat(input logic [TIME_W-1:0] period,
                                              input logic [TIME_W-1:0] delay);
        cmd_beat_t b;
        b.command = CMD_CREATE;
        b.task_period = period;
        b.start_delay = delay;
        return b;
    endfunction

    function automatic cmd_beat_t tick_beat();
        cmd_beat_t b;
        b.command = CMD_TICK;
        b.task_period = $urandom;
        b.start_delay = rand_delay();
        return b;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_OVERRIDE_SLOT)
            ovr_slot = val[OVR_SLOT_W-1:0];
        else
            ovr_period = val;
    endtask

    task automatic drain();
        while (cmd_pending.size() != 0 || cmd_valid || due_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n) begin : cmd_drive
        int gap;
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            cmd_data <= '0;
            cmd_gap <= 0;
        end
        else if (cmd_valid && !cmd_stall) begin
            schedule_step(cmd_data);
            gap = calm ? 0 : $urandom_range(0, 9);
            if (gap == 0 && cmd_pending.size() != 0) begin
                cmd_data <= cmd_pending.pop_front();
                cmd_valid <= 1'b1;
            end
            else begin
                cmd_valid <= 1'b0;
                cmd_gap <= gap;
            end
        end
        else if (!cmd_valid) begin
            if (cmd_gap != 0)
                cmd_gap <= cmd_gap - 1;
            else if (cmd_pending.size() != 0) begin
                cmd_data <= cmd_pending.pop_front();
                cmd_valid <= 1'b1;
            end
        end
    end

    // run beat monitor
    always @(posedge clk or negedge rst_n) begin : run_watch
        int        hold;
        run_beat_t want;
        if (!rst_n) begin
            run_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else if (run_valid && !run_stall) begin
            if (due_runs.size() == 0)
                flag_mismatch($sformatf("run beat with nothing due, slot %0d",
                                        run_data.task_slot));
            else begin
                want = due_runs.pop_front();
                if (run_data.task_slot !== want.task_slot)
                    flag_mismatch($sformatf("task_slot got %0d want %0d",
                                            run_data.task_slot, want.task_slot));
                if (run_data.last_due !== want.last_due)
                    flag_mismatch($sformatf("last_due got %0d want %0d on slot %0d",
                                            run_data.last_due, want.last_due,
                                            want.task_slot));
            end
            hold = calm ? 0 : $urandom_range(0, 9);
            run_stall <= (hold != 0);
            stall_cnt <= hold;
        end
        else if (run_stall) begin
            if (stall_cnt <= 1)
                run_stall <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, dead slot, always-due slot, far-off and one-shot slots
        cmd_pending.push_back(tick_beat());
        cmd_pending.push_back(create_beat(32'd0, 32'hFFFF_FFFE));
        cmd_pending.push_back(tick_beat());
        cmd_pending.push_back(create_beat(32'd1, 32'd0));
        cmd_pending.push_back(tick_beat());
        cmd_pending.push_back(create_beat(32'hFFFF_FFFF, 32'd2));
        cmd_pending.push_back(create_beat(32'd0, 32'd0));
        repeat (3) cmd_pending.push_back(tick_beat());
        repeat (SLOTS - 4)
            cmd_pending.push_back(create_beat($urandom_range(1, 7), $urandom_range(0, 7)));
        // table full: dropped
        cmd_pending.push_back(create_beat($urandom, rand_delay()));
        repeat (8) cmd_pending.push_back(tick_beat());

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(REG_OVERRIDE_SLOT, CFG_DATA_W'(PHASE_SLOT[p]));
            write_reg(REG_OVERRIDE_PERIOD, PHASE_PERIOD[p]);
            calm = (p == 2);
            @(negedge clk);
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                if ($urandom_range(0, 7) == 0)
                    cmd_pending.push_back(create_beat($urandom, rand_delay()));
                cmd_pending.push_back(tick_beat());
            end
        end
        drain();

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
